FILE: rtl/cfc_pkg.sv
// Shared types, constants and the CRC-16 byte step for the command frame checker.
// No dependencies; every other file imports this package.
package cfc_pkg;

  localparam int FRAME_BYTES   = 30;
  localparam int CRC_SPAN      = 26;
  localparam int CNT_W         = 7;
  localparam int PAYLOAD_FIRST = 4;
  localparam int PAYLOAD_LEN   = 24;
  localparam int PAY_IDX_W     = 5;
  localparam int NUM_WORDS     = PAYLOAD_LEN / 4;
  localparam int QUEUE_DEPTH   = 4;
  localparam int Q_PTR_W       = 2;
  localparam int OUT_BITS      = 200;
  localparam int ADDR_W        = 4;

  localparam logic [CNT_W-1:0] COUNT_MAX = 7'd127;
  localparam logic [15:0]      CRC_POLY  = 16'h1021;
  localparam logic [15:0]      CRC_INIT  = 16'h0000;

  typedef enum logic [1:0] {
    REG_HEADER_FIRST,
    REG_HEADER_SECOND,
    REG_LENGTH_CODE,
    REG_TYPE_CODE
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] length_code;
    logic [7:0] type_code;
  } cfg_t;

  // one classified byte, as handed from front to back
  typedef struct packed {
    logic [7:0]           data;
    logic                 last;
    logic                 mismatch;
    logic                 crc_en;
    logic                 pay_en;
    logic [PAY_IDX_W-1:0] pay_idx;
    logic                 rcrc_lo;
    logic                 rcrc_hi;
    logic                 len_ok;
  } item_t;

  typedef struct packed {
    logic [31:0] wz_word;
    logic [31:0] spare_three_word;
    logic [31:0] spare_two_word;
    logic [31:0] spare_one_word;
    logic [31:0] vy_word;
    logic [31:0] vx_word;
    logic        frame_ok;
  } result_t;

  // CRC-16/XMODEM, MSB first, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/cfc_front.sv
// Front end: accepts bytes, tracks the position in the chunk and tags each byte.
// Depends on cfc_pkg.
module cfc_front import cfc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] rx_byte,
  input  logic       last_byte,
  input  cfg_t       cfg,
  input  logic       q_full,
  output logic       push,
  output item_t      item
);

  logic [CNT_W-1:0] byte_count;
  logic [CNT_W-1:0] byte_count_next;
  logic [CNT_W-1:0] pay_off;
  logic             in_frame;

  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;
  assign in_frame = byte_count < CNT_W'(FRAME_BYTES);
  assign pay_off  = byte_count - CNT_W'(PAYLOAD_FIRST);

  always_comb begin
    item          = '0;
    item.data     = rx_byte;
    item.last     = last_byte;
    case (byte_count)
      7'd0:    item.mismatch = rx_byte != cfg.header_first;
      7'd1:    item.mismatch = rx_byte != cfg.header_second;
      7'd2:    item.mismatch = rx_byte != cfg.length_code;
      7'd3:    item.mismatch = rx_byte != cfg.type_code;
      default: item.mismatch = 1'b0;
    endcase
    item.crc_en  = in_frame && byte_count >= CNT_W'(2)
                   && byte_count < CNT_W'(2 + CRC_SPAN);
    item.pay_en  = byte_count >= CNT_W'(PAYLOAD_FIRST)
                   && byte_count < CNT_W'(PAYLOAD_FIRST + PAYLOAD_LEN);
    item.pay_idx = pay_off[PAY_IDX_W-1:0];
    item.rcrc_lo = byte_count == CNT_W'(FRAME_BYTES - 2);
    item.rcrc_hi = byte_count == CNT_W'(FRAME_BYTES - 1);
    // count after this byte reaches the frame size
    item.len_ok  = byte_count >= CNT_W'(FRAME_BYTES - 1);
  end

  always_comb begin
    byte_count_next = byte_count;
    if (push) begin
      if (last_byte) begin
        byte_count_next = '0;
      end else if (byte_count != COUNT_MAX) begin
        byte_count_next = byte_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else begin
      byte_count <= byte_count_next;
    end
  end

endmodule

FILE: rtl/cfc_queue.sv
// Small FIFO of tagged bytes between front and back.
// Depends on cfc_pkg.
module cfc_queue import cfc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  head_valid,
  output item_t head
);

  item_t              mem [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   count;

  assign full       = count == (Q_PTR_W + 1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (Q_PTR_W + 1)'(1);
        2'b01:   count <= count - (Q_PTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/cfc_back.sv
// Back end: CRC, prefix check, payload capture and the registered verdict.
// Depends on cfc_pkg.
module cfc_back import cfc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    head_valid,
  input  item_t   head,
  output logic    pop,
  output logic    m_tvalid,
  input  logic    m_tready,
  output result_t result
);

  logic [15:0] crc_acc;
  logic [15:0] received_crc;
  logic        prefix_good;
  logic [7:0]  payload_bytes [PAYLOAD_LEN];

  logic [15:0] crc_next;
  logic [15:0] rcrc_next;
  logic        prefix_next;
  logic        ok;
  logic [31:0] words [NUM_WORDS];

  // a verdict byte waits while the output register still holds one
  assign pop = head_valid && (!head.last || !m_tvalid || m_tready);

  always_comb begin
    crc_next    = head.crc_en ? crc_byte(crc_acc, head.data) : crc_acc;
    rcrc_next   = received_crc;
    if (head.rcrc_lo) begin
      rcrc_next[7:0] = head.data;
    end
    if (head.rcrc_hi) begin
      rcrc_next[15:8] = head.data;
    end
    prefix_next = prefix_good && !head.mismatch;
    ok          = head.len_ok && prefix_next && (crc_next == rcrc_next);
  end

  // a passing frame ends past the payload, so the stored bytes are complete
  always_comb begin
    for (int w = 0; w < NUM_WORDS; w++) begin
      words[w] = ok ? {payload_bytes[4*w+3], payload_bytes[4*w+2],
                       payload_bytes[4*w+1], payload_bytes[4*w]} : 32'h0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.pay_en) begin
      payload_bytes[head.pay_idx] <= head.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_acc      <= CRC_INIT;
      received_crc <= '0;
      prefix_good  <= 1'b1;
    end else if (pop) begin
      if (head.last) begin
        crc_acc      <= CRC_INIT;
        received_crc <= '0;
        prefix_good  <= 1'b1;
      end else begin
        crc_acc      <= crc_next;
        received_crc <= rcrc_next;
        prefix_good  <= prefix_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop && head.last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      result.frame_ok         <= ok;
      result.vx_word          <= words[0];
      result.vy_word          <= words[1];
      result.spare_one_word   <= words[2];
      result.spare_two_word   <= words[3];
      result.spare_three_word <= words[4];
      result.wz_word          <= words[5];
    end
  end

endmodule

FILE: rtl/command_frame_checker.sv
// Command frame checker: one byte word per cycle in, one verdict word per chunk out.
// With the queue empty, the last accepted byte is written into the queue, popped, and then registered into m_tvalid.
// Throughput: 1 byte per cycle; input stalls only when the 4-entry queue fills behind a
// verdict that the output register still holds for m_tready.
// Reset (rst, synchronous): clears byte count, queue, CRC state, output valid and
// the configuration registers; captured payload bytes are not cleared.
module command_frame_checker import cfc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] rx_byte
  input  logic                s_tlast,   // last_byte
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_BITS-1:0] m_tdata    // frame_ok, vx, vy, spare_one, spare_two,
                                         // spare_three, wz words; zero pad on top
);

  cfg_t     cfg;
  reg_idx_t reg_sel;
  logic     cfg_wr;
  logic     push;
  item_t    push_item;
  logic     q_full;
  logic     head_valid;
  item_t    head;
  logic     pop;
  result_t  result;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_HEADER_FIRST:  cfg.header_first  <= pwdata[7:0];
        REG_HEADER_SECOND: cfg.header_second <= pwdata[7:0];
        REG_LENGTH_CODE:   cfg.length_code   <= pwdata[7:0];
        REG_TYPE_CODE:     cfg.type_code     <= pwdata[7:0];
        default:           cfg               <= cfg;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_HEADER_FIRST:  prdata = {24'h0, cfg.header_first};
      REG_HEADER_SECOND: prdata = {24'h0, cfg.header_second};
      REG_LENGTH_CODE:   prdata = {24'h0, cfg.length_code};
      REG_TYPE_CODE:     prdata = {24'h0, cfg.type_code};
      default:           prdata = 32'h0;
    endcase
  end

  cfc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .rx_byte   (s_tdata),
    .last_byte (s_tlast),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (push),
    .item      (push_item)
  );

  cfc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  cfc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .result     (result)
  );

  assign m_tdata = {(OUT_BITS - $bits(result_t))'(0), result};

  // verdict byte must not overwrite a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && head_valid && head.last) |-> !pop)
    else $error("verdict popped while output stalled");

  // failed frame carries zero vx, spare_two and wz words
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !result.frame_ok) |->
      (result.vx_word == 32'h0 && result.wz_word == 32'h0
       && result.spare_two_word == 32'h0))
    else $error("failed frame with nonzero payload");

  // queue and output valid start cleared after reset, and the queue never pops when empty
  a_q_reset: assert property (@(posedge clk)
    rst |=> (!head_valid && !m_tvalid))
    else $error("queue or output not cleared by reset");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule
